/* rtl/psra_pkg.sv */
// Shared types and constants for the paged shelf rectangle allocator.
// Used by psra_front, psra_back and paged_shelf_rect_allocator_top; no dependencies.
package psra_pkg;

	// fixed field widths of the stream words
	localparam int RECT_W = 11;
	localparam int POS_W  = 11;
	localparam int PAGE_W = 2;

	// entries in the queue between front and back
	localparam int QDEPTH = 2;

	// command classes decided by the front
	typedef enum logic [1:0] {
		OP_ALLOC,
		OP_ZERO,
		OP_FLUSH
	} psra_op_t;

	// one queued command
	typedef struct packed {
		psra_op_t            op;
		logic [RECT_W-1:0]   w;
		logic [RECT_W-1:0]   h;
	} cmd_t;

	// one result word
	typedef struct packed {
		logic                kind;
		logic                ok;
		logic [PAGE_W-1:0]   page;
		logic [POS_W-1:0]    pos_x;
		logic [POS_W-1:0]    pos_y;
		logic [POS_W-1:0]    box_width;
		logic [POS_W-1:0]    box_height;
		logic                was_cleared;
		logic                last;
	} res_t;

	// back-end sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TRY,
		ST_PLACE,
		ST_FLUSH
	} back_state_t;

endpackage

/* rtl/paged_shelf_rect_allocator_top.sv */
// Paged shelf rectangle allocator: top level with stream ports.
// Depends on psra_pkg, psra_front and psra_back.
// Sequence: an allocation passes ST_IDLE, ST_TRY and ST_PLACE to the output register,
// retrying in ST_TRY when a new page opens; a zero-size command skips ST_TRY; a flush
// walks the open pages in ST_FLUSH. A full clear walks them, then retries; throughput is set
// by the back-end sequencer, which runs one command at a time; a 2-word queue decouples input.
// Reset: cursors, shelves, dirty marks and current page cleared, one page open;
// dirty box bounds are not reset and are only read once marked.
module paged_shelf_rect_allocator_top #(
	parameter int ATLAS_WIDTH  = 1024,
	parameter int ATLAS_HEIGHT = 1024,
	parameter int GUTTER       = 1,
	parameter int MAX_PAGES    = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // rect_width[10:0], rect_height[21:11], zero fill
	input  logic        s_tuser,   // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // ok, page, pos_x, pos_y, box_width, box_height, was_cleared
	output logic        m_tuser,   // kind
	output logic        m_tlast    // last
);
	import psra_pkg::*;

	logic cmd_valid;
	cmd_t cmd;
	logic cmd_pop;
	res_t res;

	// accept and classify
	psra_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.mode        (s_tuser),
		.rect_width  (s_tdata[10:0]),
		.rect_height (s_tdata[21:11]),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd),
		.cmd_pop     (cmd_pop)
	);

	// packing sequencer
	psra_back #(
		.ATLAS_WIDTH  (ATLAS_WIDTH),
		.ATLAS_HEIGHT (ATLAS_HEIGHT),
		.GUTTER       (GUTTER),
		.MAX_PAGES    (MAX_PAGES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.out_valid (m_tvalid),
		.out_word  (res),
		.out_ready (m_tready)
	);

	// output word packing, lowest field first
	assign m_tdata = {res.was_cleared, res.box_height, res.box_width,
	                  res.pos_y, res.pos_x, res.page, res.ok};
	assign m_tuser = res.kind;
	assign m_tlast = res.last;

	// a placement answer always closes its input and carries no box size
	a_place_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tlast && m_tdata[46:25] == '0))
		else $error("placement word without last or with box size");

	// dirty boxes are always ok and never flag a clear
	a_box_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[0] && !m_tdata[47]))
		else $error("dirty box word with bad flags");

	// a failed placement only follows a full clear and sits at the origin
	a_fail_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser && !m_tdata[0]) |-> (m_tdata[47] && m_tdata[24:3] == '0))
		else $error("failed placement without clear or off origin");

	// the sequencer never pops the queue while the front has no command queued
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid)
		else $error("queue popped while empty");

endmodule

/* rtl/psra_front.sv */
// Front end: accepts input words, classifies them and queues the commands.
// Depends on psra_pkg.
module psra_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       mode,
	input  logic [psra_pkg::RECT_W-1:0] rect_width,
	input  logic [psra_pkg::RECT_W-1:0] rect_height,
	output logic                       cmd_valid,
	output psra_pkg::cmd_t             cmd,
	input  logic                       cmd_pop
);
	import psra_pkg::*;

	localparam int CNT_W = $clog2(QDEPTH + 1);
	localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

	cmd_t             mem_q [QDEPTH];
	logic [CNT_W-1:0] count_q;
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	cmd_t             cls;
	logic             push;

	// classify the incoming word
	always_comb begin
		cls.w  = rect_width;
		cls.h  = rect_height;
		if (mode) begin
			cls.op = OP_FLUSH;
		end else if (rect_width == '0 || rect_height == '0) begin
			cls.op = OP_ZERO;
		end else begin
			cls.op = OP_ALLOC;
		end
	end

	assign in_ready  = (count_q != CNT_W'(QDEPTH));
	assign push      = in_valid && in_ready;
	assign cmd_valid = (count_q != '0);
	assign cmd       = mem_q[rd_q];

	// queue storage, no reset needed
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= cls;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			wr_q    <= '0;
			rd_q    <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (cmd_pop) begin
				rd_q <= (rd_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !cmd_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && cmd_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/psra_back.sv */
// Back end: shelf packing sequencer, per-page state, dirty walk and output register.
// Depends on psra_pkg.
module psra_back #(
	parameter int ATLAS_WIDTH  = 1024,
	parameter int ATLAS_HEIGHT = 1024,
	parameter int GUTTER       = 1,
	parameter int MAX_PAGES    = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  psra_pkg::cmd_t cmd,
	output logic           cmd_pop,
	output logic           out_valid,
	output psra_pkg::res_t out_word,
	input  logic           out_ready
);
	import psra_pkg::*;

	localparam int AMAX = (ATLAS_WIDTH > ATLAS_HEIGHT) ? ATLAS_WIDTH : ATLAS_HEIGHT;
	localparam int SW   = $clog2(AMAX + 1);
	localparam int CW   = $clog2(2 * AMAX + (1 << RECT_W) + GUTTER + 1);
	localparam int PW   = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam int OW   = $clog2(MAX_PAGES + 1);

	// per-page packing state
	logic [SW-1:0]        cursor_x_q [MAX_PAGES];
	logic [SW-1:0]        cursor_y_q [MAX_PAGES];
	logic [SW-1:0]        shelf_q    [MAX_PAGES];
	logic [MAX_PAGES-1:0] dirty_q;
	logic [SW-1:0]        dl_q [MAX_PAGES];
	logic [SW-1:0]        dt_q [MAX_PAGES];
	logic [SW-1:0]        dr_q [MAX_PAGES];
	logic [SW-1:0]        db_q [MAX_PAGES];

	// global and sequencer state
	back_state_t   state_q, state_d;
	cmd_t          cmd_q;
	logic [PW-1:0] cur_q;
	logic [OW-1:0] open_q;
	logic [OW-1:0] fp_q;
	logic          ok_q;
	logic          cleared_q;
	logic          opened_q;
	logic [SW-1:0] x_q;
	logic [SW-1:0] y_q;
	logic          out_valid_q;
	res_t          out_q;

	// decisions
	logic          out_free;
	logic          try_ok, try_fail, try_open, start_clr;
	logic          emit_place, emit_box, walk_step, walk_done;
	logic          do_mark, more_dirty;
	logic [PW-1:0] fp_idx, open_idx;

	// try_place datapath
	logic [CW-1:0] aw, ah, cx, cy, rh, ncx, ncy, nrh;
	logic          wrap, fits;

	// dirty box bounds of the placement
	logic [SW-1:0] x1, y1;

	assign out_free  = !out_valid_q || out_ready;
	assign fp_idx    = fp_q[PW-1:0];
	assign open_idx  = open_q[PW-1:0];
	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	// shelf fit test on the current page
	always_comb begin
		aw   = CW'(cmd_q.w) + CW'(GUTTER);
		ah   = CW'(cmd_q.h) + CW'(GUTTER);
		cx   = CW'(cursor_x_q[cur_q]);
		cy   = CW'(cursor_y_q[cur_q]);
		rh   = CW'(shelf_q[cur_q]);
		wrap = (cx + aw) > CW'(ATLAS_WIDTH);
		ncx  = wrap ? '0 : cx;
		ncy  = wrap ? cy + rh : cy;
		nrh  = wrap ? '0 : rh;
		fits = (aw <= CW'(ATLAS_WIDTH)) && (ah <= CW'(ATLAS_HEIGHT)) &&
		       ((ncy + ah) <= CW'(ATLAS_HEIGHT));
	end

	assign x1 = SW'(CW'(x_q) + CW'(cmd_q.w));
	assign y1 = SW'(CW'(y_q) + CW'(cmd_q.h));

	// any dirty open page after the walk index
	always_comb begin
		more_dirty = 1'b0;
		for (int i = 0; i < MAX_PAGES; i++) begin
			if (dirty_q[i] && (OW'(i) > fp_q) && (OW'(i) < open_q)) begin
				more_dirty = 1'b1;
			end
		end
	end

	// next state and step decisions
	always_comb begin
		state_d    = state_q;
		cmd_pop    = 1'b0;
		try_ok     = 1'b0;
		try_fail   = 1'b0;
		try_open   = 1'b0;
		start_clr  = 1'b0;
		emit_place = 1'b0;
		emit_box   = 1'b0;
		walk_step  = 1'b0;
		walk_done  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					case (cmd.op)
						OP_FLUSH: state_d = ST_FLUSH;
						OP_ZERO:  state_d = ST_PLACE;
						default:  state_d = ST_TRY;
					endcase
				end
			end
			ST_TRY: begin
				if (fits) begin
					try_ok  = 1'b1;
					state_d = ST_PLACE;
				end else if (cleared_q) begin
					try_fail = 1'b1;
					state_d  = ST_PLACE;
				end else if (!opened_q && (open_q < OW'(MAX_PAGES))) begin
					try_open = 1'b1;
				end else begin
					start_clr = 1'b1;
					state_d   = ST_FLUSH;
				end
			end
			ST_PLACE: begin
				if (out_free) begin
					emit_place = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_FLUSH: begin
				if (fp_q == open_q) begin
					walk_done = 1'b1;
					state_d   = (cmd_q.op == OP_FLUSH) ? ST_IDLE : ST_TRY;
				end else if (!dirty_q[fp_idx]) begin
					walk_step = 1'b1;
				end else if (out_free) begin
					walk_step = 1'b1;
					emit_box  = 1'b1;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign do_mark = emit_place && ok_q && (cmd_q.op == OP_ALLOC);

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			fp_q      <= '0;
			ok_q      <= 1'b0;
			cleared_q <= 1'b0;
			opened_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd_pop) begin
				fp_q      <= '0;
				ok_q      <= (cmd.op == OP_ZERO);
				cleared_q <= 1'b0;
				opened_q  <= 1'b0;
			end
			if (try_ok) begin
				ok_q <= 1'b1;
			end
			if (try_fail) begin
				ok_q <= 1'b0;
			end
			if (try_open) begin
				opened_q <= 1'b1;
			end
			if (start_clr) begin
				fp_q <= '0;
			end
			if (walk_step) begin
				fp_q <= fp_q + 1'b1;
			end
			if (walk_done && (cmd_q.op != OP_FLUSH)) begin
				cleared_q <= 1'b1;
			end
		end
	end

	// command and placement holding registers
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
			x_q   <= '0;
			y_q   <= '0;
		end
		if (try_ok) begin
			x_q <= SW'(ncx);
			y_q <= SW'(ncy);
		end
	end

	// page packing state and dirty marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_PAGES; i++) begin
				cursor_x_q[i] <= '0;
				cursor_y_q[i] <= '0;
				shelf_q[i]    <= '0;
			end
			dirty_q <= '0;
			cur_q   <= '0;
			open_q  <= OW'(1);
		end else begin
			if (try_ok) begin
				cursor_x_q[cur_q] <= SW'(ncx + aw);
				cursor_y_q[cur_q] <= SW'(ncy);
				shelf_q[cur_q]    <= SW'((ah > nrh) ? ah : nrh);
			end
			if (try_open) begin
				cursor_x_q[open_idx] <= '0;
				cursor_y_q[open_idx] <= '0;
				shelf_q[open_idx]    <= '0;
				dirty_q[open_idx]    <= 1'b0;
				cur_q                <= open_idx;
				open_q               <= open_q + 1'b1;
			end
			if (emit_box) begin
				dirty_q[fp_idx] <= 1'b0;
			end
			if (do_mark) begin
				dirty_q[cur_q] <= 1'b1;
			end
			// full clear after the pending boxes went out
			if (walk_done && (cmd_q.op != OP_FLUSH)) begin
				for (int i = 0; i < MAX_PAGES; i++) begin
					cursor_x_q[i] <= '0;
					cursor_y_q[i] <= '0;
					shelf_q[i]    <= '0;
				end
				dirty_q <= '0;
				cur_q   <= '0;
				open_q  <= OW'(1);
			end
		end
	end

	// dirty bounding boxes, first mark loads, later marks widen
	always_ff @(posedge clk) begin
		if (do_mark) begin
			if (!dirty_q[cur_q]) begin
				dl_q[cur_q] <= x_q;
				dt_q[cur_q] <= y_q;
				dr_q[cur_q] <= x1;
				db_q[cur_q] <= y1;
			end else begin
				if (x_q < dl_q[cur_q]) dl_q[cur_q] <= x_q;
				if (y_q < dt_q[cur_q]) dt_q[cur_q] <= y_q;
				if (x1 > dr_q[cur_q])  dr_q[cur_q] <= x1;
				if (y1 > db_q[cur_q])  db_q[cur_q] <= y1;
			end
		end
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_place || emit_box) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (emit_place) begin
			out_q.kind        <= 1'b0;
			out_q.ok          <= ok_q;
			out_q.page        <= PAGE_W'(cur_q);
			out_q.pos_x       <= ok_q ? POS_W'(x_q) : '0;
			out_q.pos_y       <= ok_q ? POS_W'(y_q) : '0;
			out_q.box_width   <= '0;
			out_q.box_height  <= '0;
			out_q.was_cleared <= cleared_q;
			out_q.last        <= 1'b1;
		end else if (emit_box) begin
			out_q.kind        <= 1'b1;
			out_q.ok          <= 1'b1;
			out_q.page        <= PAGE_W'(fp_idx);
			out_q.pos_x       <= POS_W'(dl_q[fp_idx]);
			out_q.pos_y       <= POS_W'(dt_q[fp_idx]);
			out_q.box_width   <= POS_W'(dr_q[fp_idx] - dl_q[fp_idx]);
			out_q.box_height  <= POS_W'(db_q[fp_idx] - dt_q[fp_idx]);
			out_q.was_cleared <= 1'b0;
			out_q.last        <= (cmd_q.op == OP_FLUSH) && !more_dirty;
		end
	end

endmodule
